FILE: rtl/assert_macros.svh
// assertion macros used by the port checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TBP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tbp assertion failed");

// next-cycle implication, disabled while in reset
`define TBP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tbp assertion failed");

`endif

FILE: rtl/tbp_pkg.sv
// constants, codes and types of the token bucket policer table
// no dependencies
`default_nettype none

package tbp_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int OP_W     = 3;
  localparam int KEY_W    = 8;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 32;
  localparam int BURST_W  = 32;
  localparam int LEN_W    = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int PKT_W    = 32;
  localparam int BYTE_W   = 64;
  localparam int TOK_W    = 32;

  localparam logic [KEY_W-1:0] WILDCARD_KEY = 8'hFF;

  // refill divider: rate * delta_ms / 8000
  localparam int MS_BITS_PER_BYTE = 8000;
  localparam int PROD_W           = RATE_W + TIME_W;
  localparam int DIV_RADIX_BITS   = 8;
  localparam int DIV_STEPS        = PROD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
  localparam int REM_W            = $clog2(MS_BITS_PER_BYTE);

  localparam logic [OP_W-1:0] OP_ADMIT = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [BURST_W-1:0] burst;
    logic [TOK_W-1:0]   tokens;
    logic [TIME_W-1:0]  last_time;
    logic [PKT_W-1:0]   pass_pkts;
    logic [BYTE_W-1:0]  pass_bytes;
    logic [PKT_W-1:0]   drop_pkts;
    logic [BYTE_W-1:0]  drop_bytes;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                verdict;
    logic                entry_active;
    logic [PKT_W-1:0]    pass_packets;
    logic [BYTE_W-1:0]   pass_bytes;
    logic [PKT_W-1:0]    drop_packets;
    logic [BYTE_W-1:0]   drop_bytes;
    logic [TOK_W-1:0]    tokens_left;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/tbp_ifs.sv
// valid/ready channel interfaces for input and result words
// depends on tbp_pkg
`default_nettype none

interface tbp_in_if import tbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    iface_key;
  logic [TIME_W-1:0]   time_ms;
  logic [RATE_W-1:0]   rate_bits;
  logic [BURST_W-1:0]  burst_size;
  logic [LEN_W-1:0]    packet_length;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, op, iface_key, time_ms, rate_bits, burst_size,
                  packet_length, slot, input ready);
  modport sink (input valid, op, iface_key, time_ms, rate_bits, burst_size,
                packet_length, slot, output ready);
endinterface

interface tbp_out_if import tbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic                verdict;
  logic                entry_active;
  logic [PKT_W-1:0]    pass_packets;
  logic [BYTE_W-1:0]   pass_bytes;
  logic [PKT_W-1:0]    drop_packets;
  logic [BYTE_W-1:0]   drop_bytes;
  logic [TOK_W-1:0]    tokens_left;

  modport source (output valid, status, slot_index, verdict, entry_active,
                  pass_packets, pass_bytes, drop_packets, drop_bytes, tokens_left,
                  input ready);
  modport sink (input valid, status, slot_index, verdict, entry_active,
                pass_packets, pass_bytes, drop_packets, drop_bytes, tokens_left,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/token_bucket_policer_table.sv
// token bucket policer table: one word in, one result word out, one item at a time
// admit: key scan, entry read, time delta, multiply, divide by 8000, bucket update
// add/delete: key scan, then table update; flush, read stats, early rejects: no scan
// next word taken in the cycle after the result loads; a stalled result holds off the load
// the key scan runs over every slot; the divide by 8000 runs byte-a-cycle
// synchronous active-low reset empties the table; the entry memory is not cleared
// depends on tbp_pkg, tbp_ifs, tbp_div8k, tbp_store
`default_nettype none

module token_bucket_policer_table import tbp_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  tbp_in_if.sink   in_ch,
  tbp_out_if.source out_ch
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SDEC  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_DLT   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_UPD1  = 4'd8;
  localparam logic [3:0] S_UPD2  = 4'd9;
  localparam logic [3:0] S_RSTAT = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;

  // latched input word
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   ikey_r;
  logic [TIME_W-1:0]  time_r;
  logic [RATE_W-1:0]  rate_r;
  logic [BURST_W-1:0] burst_r;
  logic [LEN_W-1:0]   len_r;

  // slot valid bits and keys in flops, the rest in the entry memory
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]         keys_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]         used_r;

  // scan results
  logic [IDX_W-1:0] cnt_r;
  logic             ex_hit_r, wc_hit_r, fr_hit_r;
  logic [IDX_W-1:0] ex_idx_r, wc_idx_r, fr_idx_r;
  logic [IDX_W-1:0] rd_idx_r;

  // refill datapath
  logic [TIME_W-1:0] delta_r;
  logic [PROD_W-1:0] prod_r;
  logic [TOK_W-1:0]  tok_r;

  result_t res_r, out_r;
  logic    out_valid_r;

  // entry memory and divider hookup
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           rdata;
  logic             div_start, div_done;
  logic [PROD_W-1:0] quo;

  logic             in_acc;
  logic [IDX_W-1:0] in_sidx;
  logic             in_slot_ok;
  logic [STATUS_W-1:0] in_status;
  logic             add_ok;
  logic [PROD_W:0]  refill_sum;
  logic [TOK_W-1:0] tok_new;
  logic             pass;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_sidx     = IDX_W'(in_ch.slot);
  assign in_slot_ok  = ({{(32-SLOT_W){1'b0}}, in_ch.slot} < 32'(TABLE_ENTRIES))
                       && valid_r[in_sidx];

  // status known right at accept: zero rate, missing stats slot, unknown op
  always_comb begin
    in_status = ST_OK;
    unique case (in_ch.op)
      OP_ADD: begin
        if (in_ch.rate_bits == '0) begin
          in_status = ST_INVALID;
        end
      end
      OP_READ: begin
        if (!in_slot_ok) begin
          in_status = ST_NOTFOUND;
        end
      end
      OP_ADMIT, OP_DEL, OP_FLUSH: ;
      default: in_status = ST_INVALID;
    endcase
  end

  // add goes through only with no duplicate and a free slot
  assign add_ok = (op_r == OP_ADD) && !ex_hit_r && fr_hit_r
                  && (used_r != CNT_W'(TABLE_ENTRIES));

  // bucket refill, clamped to burst; a zero refill leaves the bucket alone
  assign refill_sum = {1'b0, PROD_W'(rdata.tokens)} + {1'b0, quo};

  // pass decision on the refilled bucket
  assign pass    = (tok_r >= TOK_W'(len_r));
  assign tok_new = pass ? (tok_r - TOK_W'(len_r)) : tok_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fr_idx_r;
    mem_wdata = rdata;
    if (state_r == S_SDEC && add_ok) begin
      mem_we               = 1'b1;
      mem_wdata.rate       = rate_r;
      mem_wdata.burst      = burst_r;
      mem_wdata.tokens     = burst_r;
      mem_wdata.last_time  = time_r;
      mem_wdata.pass_pkts  = '0;
      mem_wdata.pass_bytes = '0;
      mem_wdata.drop_pkts  = '0;
      mem_wdata.drop_bytes = '0;
    end else if (state_r == S_UPD2) begin
      mem_we              = 1'b1;
      mem_waddr           = rd_idx_r;
      mem_wdata.tokens    = tok_new;
      mem_wdata.last_time = time_r;
      if (pass) begin
        mem_wdata.pass_pkts  = rdata.pass_pkts + PKT_W'(1);
        mem_wdata.pass_bytes = rdata.pass_bytes + BYTE_W'(len_r);
      end else begin
        mem_wdata.drop_pkts  = rdata.drop_pkts + PKT_W'(1);
        mem_wdata.drop_bytes = rdata.drop_bytes + BYTE_W'(len_r);
      end
    end
  end

  assign div_start = (state_r == S_DIVS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.op)
            OP_ADMIT: state_nxt = (in_ch.packet_length == '0) ? S_DONE : S_SCAN;
            OP_ADD:   state_nxt = (in_ch.rate_bits == '0) ? S_DONE : S_SCAN;
            OP_DEL:   state_nxt = S_SCAN;
            OP_READ:  state_nxt = in_slot_ok ? S_RD : S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN:  state_nxt = (cnt_r == IDX_W'(TABLE_ENTRIES - 1)) ? S_SDEC : S_SCAN;
      S_SDEC:  state_nxt = ((op_r == OP_ADMIT) && (ex_hit_r || wc_hit_r)) ? S_RD : S_DONE;
      S_RD:    state_nxt = (op_r == OP_ADMIT) ? S_DLT : S_RSTAT;
      S_DLT:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIVS;
      S_DIVS:  state_nxt = S_DIVW;
      S_DIVW:  state_nxt = div_done ? S_UPD1 : S_DIVW;
      S_UPD1:  state_nxt = S_UPD2;
      S_UPD2:  state_nxt = S_DONE;
      S_RSTAT: state_nxt = S_DONE;
      S_DONE:  state_nxt = (!out_valid_r || out_ch.ready) ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      ex_hit_r    <= 1'b0;
      wc_hit_r    <= 1'b0;
      fr_hit_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // output register, refilled only once the previous word is taken
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_r       <= res_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_ch.op;
            ikey_r   <= in_ch.iface_key;
            time_r   <= in_ch.time_ms;
            rate_r   <= in_ch.rate_bits;
            burst_r  <= in_ch.burst_size;
            len_r    <= in_ch.packet_length;
            rd_idx_r <= in_sidx;
            cnt_r    <= '0;
            ex_hit_r <= 1'b0;
            wc_hit_r <= 1'b0;
            fr_hit_r <= 1'b0;
            res_r    <= '{status: in_status, default: '0};
            if (in_ch.op == OP_FLUSH) begin
              valid_r <= '0;
              used_r  <= '0;
            end
          end
        end

        // one slot a cycle, first match of each kind wins
        S_SCAN: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (valid_r[cnt_r] && keys_r[cnt_r] == ikey_r && !ex_hit_r) begin
            ex_hit_r <= 1'b1;
            ex_idx_r <= cnt_r;
          end
          if (valid_r[cnt_r] && keys_r[cnt_r] == WILDCARD_KEY && !wc_hit_r) begin
            wc_hit_r <= 1'b1;
            wc_idx_r <= cnt_r;
          end
          if (!valid_r[cnt_r] && !fr_hit_r) begin
            fr_hit_r <= 1'b1;
            fr_idx_r <= cnt_r;
          end
        end

        S_SDEC: begin
          unique case (op_r)
            OP_ADMIT: begin
              // exact key first, then the wildcard entry
              rd_idx_r <= ex_hit_r ? ex_idx_r : wc_idx_r;
            end
            OP_ADD: begin
              if (ex_hit_r) begin
                res_r.status <= ST_DUP;
              end else if (!add_ok) begin
                res_r.status <= ST_FULL;
              end else begin
                valid_r[fr_idx_r] <= 1'b1;
                keys_r[fr_idx_r]  <= ikey_r;
                used_r            <= used_r + CNT_W'(1);
                res_r.slot_index  <= SLOT_W'(fr_idx_r);
                res_r.tokens_left <= burst_r;
              end
            end
            OP_DEL: begin
              if (ex_hit_r) begin
                valid_r[ex_idx_r] <= 1'b0;
                if (used_r != '0) begin
                  used_r <= used_r - CNT_W'(1);
                end
              end else begin
                res_r.status <= ST_NOTFOUND;
              end
            end
            default: ;
          endcase
        end

        S_DLT: delta_r <= time_r - rdata.last_time;
        S_MUL: prod_r  <= PROD_W'(rdata.rate) * PROD_W'(delta_r);

        S_UPD1: begin
          if (quo == '0) begin
            tok_r <= rdata.tokens;
          end else if (refill_sum > (PROD_W+1)'(rdata.burst)) begin
            tok_r <= rdata.burst;
          end else begin
            tok_r <= refill_sum[TOK_W-1:0];
          end
        end

        S_UPD2: begin
          res_r.verdict     <= !pass;
          res_r.tokens_left <= tok_new;
        end

        S_RSTAT: begin
          res_r.entry_active <= 1'b1;
          res_r.pass_packets <= rdata.pass_pkts;
          res_r.pass_bytes   <= rdata.pass_bytes;
          res_r.drop_packets <= rdata.drop_pkts;
          res_r.drop_bytes   <= rdata.drop_bytes;
          res_r.tokens_left  <= rdata.tokens;
        end

        default: ;
      endcase
    end
  end

  tbp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  tbp_div8k u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.slot_index   = out_r.slot_index;
  assign out_ch.verdict      = out_r.verdict;
  assign out_ch.entry_active = out_r.entry_active;
  assign out_ch.pass_packets = out_r.pass_packets;
  assign out_ch.pass_bytes   = out_r.pass_bytes;
  assign out_ch.drop_packets = out_r.drop_packets;
  assign out_ch.drop_bytes   = out_r.drop_bytes;
  assign out_ch.tokens_left  = out_r.tokens_left;

endmodule

`default_nettype wire

FILE: rtl/tbp_div8k.sv
// iterative divide of the refill product by 8000, one byte of quotient per cycle
// depends on tbp_pkg
`default_nettype none

module tbp_div8k import tbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  output logic                   done,
  output logic [PROD_W-1:0]      quotient
);

  localparam logic [REM_W:0] DIV_K = (REM_W+1)'(MS_BITS_PER_BYTE);

  logic                      busy_r;
  logic                      done_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic [PROD_W-1:0]         dvd_r;
  logic [PROD_W-1:0]         quo_r;
  logic [REM_W-1:0]          rem_r;
  logic [REM_W-1:0]          rem_nxt;
  logic [DIV_RADIX_BITS-1:0] qdig;
  logic [REM_W:0]            trial;

  // restoring steps over the top byte of the shifted dividend
  always_comb begin
    rem_nxt = rem_r;
    qdig    = '0;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_nxt, dvd_r[PROD_W-1-i]};
      if (trial >= DIV_K) begin
        trial = trial - DIV_K;
        qdig[DIV_RADIX_BITS-1-i] = 1'b1;
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        quo_r  <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << DIV_RADIX_BITS;
        quo_r <= {quo_r[PROD_W-DIV_RADIX_BITS-1:0], qdig};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/tbp_store.sv
// per-slot policer entry memory, one write and one registered read port
// depends on tbp_pkg
`default_nettype none

module tbp_store import tbp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output entry_t                rdata
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/tbp_checker.sv
// port-level checks of the policer table, bound to the top level
// depends on tbp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tbp_port_checker import tbp_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic                out_verdict,
  input wire logic                out_entry_active,
  input wire logic [TOK_W-1:0]    out_tokens_left
);

  // one word at a time: an accepted word closes the input
  `TBP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a drop only comes from a found entry, with no stats attached
  `TBP_ASSERT_IMP(a_drop_ok, clk, rst_n, out_valid && out_verdict, (out_status == ST_OK) && !out_entry_active)

  // stats are only reported with an ok status
  `TBP_ASSERT_IMP(a_stats_ok, clk, rst_n, out_valid && out_entry_active, out_status == ST_OK)

  // a stalled result word holds
  `TBP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_tokens_left))

endmodule

bind token_bucket_policer_table tbp_port_checker u_tbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_verdict      (out_ch.verdict),
  .out_entry_active (out_ch.entry_active),
  .out_tokens_left  (out_ch.tokens_left)
);

`default_nettype wire

FILE: test/tbp_checker.sv
// checker for the token bucket policer table: watches both channels, predicts results
// depends on tbp_pkg and tbp_ifs
`default_nettype none

module tbp_checker import tbp_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  tbp_in_if.sink   in_mon,
  tbp_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                pol_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]    pol_key   [TABLE_ENTRIES];
  entry_t              pol       [TABLE_ENTRIES];
  result_t             expected_results[$];

  initial fail_count = 0;
  assign pending_words = expected_results.size();

  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int s = 0; s < TABLE_ENTRIES; s++)
      if (pol_valid[s] && pol_key[s] == k) return s;
    return -1;
  endfunction

  task automatic police_word();
    result_t r;
    int s;
    logic [31:0] delta;
    logic [63:0] refill;
    logic [63:0] t;
    r = '0;
    case (in_mon.op)
      OP_ADMIT: if (in_mon.packet_length != 0) begin
        s = find_key(in_mon.iface_key);
        if (s < 0) s = find_key(WILDCARD_KEY);
        if (s >= 0) begin
          delta = in_mon.time_ms - pol[s].last_time;
          pol[s].last_time = in_mon.time_ms;
          refill = (64'(pol[s].rate) * 64'(delta)) / 64'(MS_BITS_PER_BYTE);
          if (refill != 0) begin
            t = 64'(pol[s].tokens) + refill;
            if (t > 64'(pol[s].burst)) t = 64'(pol[s].burst);
            pol[s].tokens = t[31:0];
          end
          if (pol[s].tokens >= 32'(in_mon.packet_length)) begin
            pol[s].tokens -= 32'(in_mon.packet_length);
            pol[s].pass_pkts += 1;
            pol[s].pass_bytes += 64'(in_mon.packet_length);
          end else begin
            pol[s].drop_pkts += 1;
            pol[s].drop_bytes += 64'(in_mon.packet_length);
            r.verdict = 1'b1;
          end
          r.tokens_left = pol[s].tokens;
        end
      end
      OP_ADD: begin
        if (in_mon.rate_bits == 0) r.status = ST_INVALID;
        else if (find_key(in_mon.iface_key) >= 0) r.status = ST_DUP;
        else begin
          s = -1;
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) if (!pol_valid[i]) s = i;
          if (s < 0) r.status = ST_FULL;
          else begin
            pol_valid[s] = 1'b1;
            pol_key[s] = in_mon.iface_key;
            pol[s] = '0;
            pol[s].rate = in_mon.rate_bits;
            pol[s].burst = in_mon.burst_size;
            pol[s].tokens = in_mon.burst_size;
            pol[s].last_time = in_mon.time_ms;
            r.slot_index = SLOT_W'(s);
            r.tokens_left = in_mon.burst_size;
          end
        end
      end
      OP_DEL: begin
        s = find_key(in_mon.iface_key);
        if (s < 0) r.status = ST_NOTFOUND;
        else pol_valid[s] = 1'b0;
      end
      OP_FLUSH: for (int i = 0; i < TABLE_ENTRIES; i++) pol_valid[i] = 1'b0;
      OP_READ: begin
        if (int'(in_mon.slot) >= TABLE_ENTRIES || !pol_valid[in_mon.slot])
          r.status = ST_NOTFOUND;
        else begin
          r.entry_active = 1'b1;
          r.pass_packets = pol[in_mon.slot].pass_pkts;
          r.pass_bytes   = pol[in_mon.slot].pass_bytes;
          r.drop_packets = pol[in_mon.slot].drop_pkts;
          r.drop_bytes   = pol[in_mon.slot].drop_bytes;
          r.tokens_left  = pol[in_mon.slot].tokens;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) pol_valid[i] = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.slot_index, out_mon.verdict, out_mon.entry_active,
                out_mon.pass_packets, out_mon.pass_bytes, out_mon.drop_packets,
                out_mon.drop_bytes, out_mon.tokens_left};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) police_word();
    end
  end
endmodule

`default_nettype wire

FILE: test/tb_token_bucket_policer_table.sv
// top of the policer table testbench: clock, reset, stimulus and verdict
// depends on tbp_pkg, tbp_ifs, tbp_checker and the block itself
`default_nettype none

module tb_token_bucket_policer_table;
  import tbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count, pending_words;
  int cycle_count = 0;

  always #1 clk = ~clk;

  tbp_in_if  in_ch();
  tbp_out_if out_ch();

  token_bucket_policer_table dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  tbp_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                   .fail_count(fail_count), .pending_words(pending_words));

  // run limit: slow admits plus long gaps on both sides, many times over
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // sink side stalls independently of the source
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      int g;
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // time runs mostly forward in small steps, with the odd jump
  logic [31:0] now_ms = 32'd0;
  logic [7:0]  key_pool[4] = '{8'd1, 8'd7, 8'd200, WILDCARD_KEY};

  // send one word and hold it until accepted
  task automatic send_word(logic [2:0] op, logic [7:0] k, logic [31:0] tm, logic [31:0] rate,
                           logic [31:0] burst, logic [15:0] len, logic [3:0] sl);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op; in_ch.iface_key <= k; in_ch.time_ms <= tm;
    in_ch.rate_bits <= rate; in_ch.burst_size <= burst;
    in_ch.packet_length <= len; in_ch.slot <= sl;
    @(posedge clk iff in_ch.ready);
  endtask

  task automatic random_word();
    int p;
    logic [7:0] k;
    p = $urandom_range(0, 99);
    now_ms = ($urandom_range(0, 19) == 0) ? $urandom() : now_ms + $urandom_range(0, 50);
    k = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : key_pool[$urandom_range(0, 3)];
    if (p < 50)
      send_word(OP_ADMIT, k, now_ms, $urandom(), $urandom(),
                ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1500)),
                4'($urandom()));
    else if (p < 70)
      send_word(OP_ADD, k, now_ms,
                ($urandom_range(0, 9) == 0) ? 32'd0 :
                ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(8000, 2000000)),
                ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 20000)),
                16'($urandom()), 4'($urandom()));
    else if (p < 78)
      send_word(OP_DEL, k, now_ms, $urandom(), $urandom(), 16'($urandom()), 4'($urandom()));
    else if (p < 80)
      send_word(OP_FLUSH, k, now_ms, $urandom(), $urandom(), 16'($urandom()), 4'($urandom()));
    else if (p < 97)
      send_word(OP_READ, k, now_ms, $urandom(), $urandom(), 16'($urandom()), 4'($urandom()));
    else
      send_word(3'($urandom_range(5, 7)), k, now_ms, $urandom(), $urandom(),
                16'($urandom()), 4'($urandom()));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADMIT; in_ch.iface_key = '0; in_ch.time_ms = '0;
    in_ch.rate_bits = '0; in_ch.burst_size = '0; in_ch.packet_length = '0; in_ch.slot = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table admit, zero rate, duplicate, refill edge cases, wrap
    send_word(OP_ADMIT, 8'd5, 32'd0, 32'd0, 32'd0, 16'd100, 4'd0);
    send_word(OP_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send_word(OP_ADD, 8'd5, 32'd10, 32'd0, 32'd100, 16'd0, 4'd0);
    send_word(OP_ADD, 8'd5, 32'hFFFF_FFF0, 32'd8000, 32'd100, 16'd0, 4'd0);
    send_word(OP_ADD, 8'd5, 32'd0, 32'd8000, 32'd100, 16'd0, 4'd0);
    send_word(OP_ADMIT, 8'd5, 32'd5, 32'd0, 32'd0, 16'd0, 4'd0);
    send_word(OP_ADMIT, 8'd5, 32'hFFFF_FFF0, 32'd0, 32'd0, 16'd60, 4'd0);
    send_word(OP_ADMIT, 8'd5, 32'hFFFF_FFF0, 32'd0, 32'd0, 16'd60, 4'd0);
    send_word(OP_ADMIT, 8'd5, 32'd20, 32'd0, 32'd0, 16'hFFFF, 4'd0);
    send_word(OP_ADD, WILDCARD_KEY, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 4'd0);
    send_word(OP_ADMIT, 8'd9, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'hFFFF, 4'd0);
    send_word(OP_ADMIT, 8'd9, 32'd1, 32'd1, 32'd0, 16'd1, 4'd0);
    send_word(OP_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd1);
    send_word(OP_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd15);
    for (int i = 0; i < 15; i++)
      send_word(OP_ADD, 8'(i + 20), 32'd0, 32'd1, 32'd0, 16'd0, 4'd0);
    send_word(OP_ADD, 8'd99, 32'd0, 32'd1, 32'd0, 16'd0, 4'd0);
    send_word(OP_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd15);
    send_word(OP_DEL, 8'd5, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send_word(OP_DEL, 8'd5, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send_word(3'd7, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send_word(OP_FLUSH, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);

    for (int n = 0; n < 400; n++) random_word();
    in_ch.valid <= 1'b0;

    // drain, then allow for the slowest op's latency
    @(posedge clk iff pending_words == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
